>>> design/fir_lowpass_104_tap_assert.svh
// ----------------------------------------------------------------------------
// FIR low-pass assertion macros
// Shorthand for clocked properties on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIR_LOWPASS_104_TAP_ASSERT_SVH
`define FIR_LOWPASS_104_TAP_ASSERT_SVH

// Same-cycle implication
`define FLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/flp104_pkg.sv
// ----------------------------------------------------------------------------
// FIR low-pass package
// Default sizes, coefficient ROM and controller/datapath interface types.
// ----------------------------------------------------------------------------
package flp104_pkg;

  localparam int TAP_COUNT    = 104;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;

  // ROM holds Q1.17 values
  localparam int ROM_TAPS = 104;
  localparam int ROM_FRAC = 17;

  localparam logic signed [17:0] COEF_ROM [ROM_TAPS] = '{
    -18'sd594, -18'sd56, -18'sd54, -18'sd50, -18'sd42, -18'sd30, -18'sd15, 18'sd5,
    18'sd29, 18'sd58, 18'sd92, 18'sd132, 18'sd176, 18'sd227, 18'sd283, 18'sd345,
    18'sd412, 18'sd486, 18'sd565, 18'sd650, 18'sd741, 18'sd837, 18'sd939, 18'sd1044,
    18'sd1154, 18'sd1269, 18'sd1387, 18'sd1508, 18'sd1632, 18'sd1757, 18'sd1884,
    18'sd2012, 18'sd2139, 18'sd2266, 18'sd2392, 18'sd2515, 18'sd2636, 18'sd2752,
    18'sd2865, 18'sd2972, 18'sd3073, 18'sd3169, 18'sd3257, 18'sd3337, 18'sd3410,
    18'sd3474, 18'sd3528, 18'sd3573, 18'sd3609, 18'sd3635, 18'sd3650, 18'sd3655,
    18'sd3650, 18'sd3635, 18'sd3609, 18'sd3573, 18'sd3528, 18'sd3474, 18'sd3410,
    18'sd3337, 18'sd3257, 18'sd3169, 18'sd3073, 18'sd2972, 18'sd2865, 18'sd2752,
    18'sd2636, 18'sd2515, 18'sd2392, 18'sd2266, 18'sd2139, 18'sd2012, 18'sd1884,
    18'sd1757, 18'sd1632, 18'sd1508, 18'sd1387, 18'sd1269, 18'sd1154, 18'sd1044,
    18'sd939, 18'sd837, 18'sd741, 18'sd650, 18'sd565, 18'sd486, 18'sd412, 18'sd345,
    18'sd283, 18'sd227, 18'sd176, 18'sd132, 18'sd92, 18'sd58, 18'sd29, 18'sd5,
    -18'sd15, -18'sd30, -18'sd42, -18'sd50, -18'sd54, -18'sd56, -18'sd594, 18'sd0
  };

  // Coefficient k scaled to cw-1 fraction bits; round half up when narrowing
  function automatic logic signed [31:0] coef_at(input int unsigned k, input int cw);
    logic signed [31:0] c;
    logic [6:0]         idx;
    if (k >= ROM_TAPS) begin
      return 32'sd0;
    end
    idx = 7'(k);
    c   = 32'(COEF_ROM[idx]);
    if (cw - 1 >= ROM_FRAC) begin
      c = c <<< (cw - 1 - ROM_FRAC);
    end else begin
      c = (c + (32'sd1 <<< (ROM_FRAC - cw))) >>> (ROM_FRAC - cw + 1);
    end
    return c;
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic load;      // store the accepted item, restart the tap sweep
    logic issue;     // read one tap and step the address
    logic out_load;  // capture the rounded result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tap_last;  // current read is the final tap
  } status_t;

endpackage

>>> design/flp104_datapath.sv
// ----------------------------------------------------------------------------
// FIR low-pass datapath
// Delay-line memory, coefficient ROM, shared multiply-accumulate and the
// round/saturate output register.
// ----------------------------------------------------------------------------
module flp104_datapath #(
  parameter int TAP_COUNT    = flp104_pkg::TAP_COUNT,
  parameter int SAMPLE_WIDTH = flp104_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = flp104_pkg::COEF_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  flp104_pkg::cmd_t               cmd_i,
  output flp104_pkg::status_t            status_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_o
);

  localparam int AW     = $clog2(TAP_COUNT);
  localparam int FW     = $clog2(TAP_COUNT + 1);
  localparam int SUMW   = FW + 1;
  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int FULL_W = PROD_W + $clog2(TAP_COUNT);
  localparam int ACC_W  = (FULL_W > 64) ? 64 : FULL_W;
  localparam int RW     = ACC_W + 1;

  localparam logic signed [RW-1:0] HALF   = {{(RW-1){1'b0}}, 1'b1} << (COEF_WIDTH - 2);
  localparam logic signed [RW-1:0] SAT_HI =
    ({{(RW-1){1'b0}}, 1'b1} << (SAMPLE_WIDTH - 1)) - {{(RW-1){1'b0}}, 1'b1};
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  logic signed [SAMPLE_WIDTH-1:0] mem [TAP_COUNT];

  logic [AW-1:0]                  wp_q, addr_q, k_q;
  logic [FW-1:0]                  fill_q;
  logic signed [SAMPLE_WIDTH-1:0] rd_q;
  logic                           rd_ok_q;
  logic                           v1_q, v2_q;
  logic signed [COEF_WIDTH-1:0]   coef_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [31:0]             coef_raw;
  logic                           slot_ok;
  logic signed [SAMPLE_WIDTH-1:0] rd_sel;
  logic signed [RW-1:0]           rounded;
  logic signed [RW-1:0]           shifted;
  logic signed [SAMPLE_WIDTH-1:0] sat;

  // A slot holds a real sample once enough items have filled the line
  assign slot_ok  = (SUMW'(addr_q) + SUMW'(fill_q)) >= SUMW'(TAP_COUNT);
  assign coef_raw = flp104_pkg::coef_at(32'(k_q), COEF_WIDTH);
  assign status_o.tap_last = (k_q == AW'(TAP_COUNT - 1));

  // Write the new sample, read one tap a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[wp_q] <= sample_i;
    end
    rd_q <= mem[addr_q];
  end

  // Pointers, fill count and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= AW'(TAP_COUNT - 1);
      addr_q  <= '0;
      k_q     <= '0;
      fill_q  <= '0;
      rd_ok_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      v1_q    <= cmd_i.issue;
      v2_q    <= v1_q;
      rd_ok_q <= slot_ok;
      if (cmd_i.load) begin
        addr_q <= wp_q;
        k_q    <= '0;
        wp_q   <= (wp_q == '0) ? AW'(TAP_COUNT - 1) : wp_q - AW'(1);
        if (fill_q != FW'(TAP_COUNT)) begin
          fill_q <= fill_q + FW'(1);
        end
      end else if (cmd_i.issue) begin
        addr_q <= (addr_q == AW'(TAP_COUNT - 1)) ? '0 : addr_q + AW'(1);
        k_q    <= k_q + AW'(1);
      end
    end
  end

  // Multiply, then accumulate
  assign rd_sel = rd_ok_q ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    coef_q <= coef_raw[COEF_WIDTH-1:0];
    prod_q <= rd_sel * coef_q;
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Round half up, then clamp to the sample range
  assign rounded = RW'(acc_q) + HALF;
  assign shifted = rounded >>> (COEF_WIDTH - 1);

  always_comb begin
    if (shifted > SAT_HI) begin
      sat = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (shifted < SAT_LO) begin
      sat = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat = shifted[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sample_o <= sat;
    end
  end

endmodule

>>> design/flp104_ctrl.sv
// ----------------------------------------------------------------------------
// FIR low-pass controller
// Sequences accept, tap sweep, pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
module flp104_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output flp104_pkg::cmd_t    cmd_o,
  input  flp104_pkg::status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Decode commands from the state
  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.issue    = (state_q == ST_RUN);
  assign cmd_o.out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Advance state, track the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (status_i.tap_last) state_q <= ST_DRAIN1;
        end
        ST_DRAIN1: begin
          state_q <= ST_DRAIN2;
        end
        ST_DRAIN2: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/fir_lowpass_104_tap.sv
// Flow: an item is swept tap by tap in ST_RUN, drained through ST_DRAIN1 and
// ST_DRAIN2 and loaded into the output in ST_FIN; only then is a new item taken,
// due to the single multiply-accumulate and the one delay-line memory read port.
// Reset: rst_ni clears control at once; unwritten delay slots read as zero
// through a fill count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// FIR low-pass filter, 104 taps
// Direct-form FIR on a circular delay line, fixed coefficient ROM symmetric
// but for its zero last tap; the sum is rounded to the sample format, saturated.
// ----------------------------------------------------------------------------
module fir_lowpass_104_tap #(
  parameter int TAP_COUNT    = flp104_pkg::TAP_COUNT,
  parameter int SAMPLE_WIDTH = flp104_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = flp104_pkg::COEF_WIDTH,
  parameter int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,   // sample_in, zero pad above
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o    // sample_out, zero pad above
);

  `include "fir_lowpass_104_tap_assert.svh"

  flp104_pkg::cmd_t               cmd;
  flp104_pkg::status_t            status;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  flp104_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  flp104_datapath #(
    .TAP_COUNT    (TAP_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .sample_i (s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .sample_o (sample_out)
  );

  // Pad the result to whole bytes
  assign m_axis_tdata_o = DATA_W'($unsigned(sample_out));

  // Checks
  `FLP_ASSERT_NOW(a_load_is_accept, 1'b1, cmd.load == (s_axis_tvalid_i && s_axis_tready_o), "load without matching accept")
  `FLP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "ready while sweeping taps")
  `FLP_ASSERT_NOW(a_last_only_in_sweep, status.tap_last && !cmd.load && cmd.issue == 1'b0, !cmd.out_load || !cmd.issue, "result captured during sweep")

endmodule

>>> tb/fir_lowpass_104_tap_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FIR low-pass 104-tap testbench
// Streams signed Q1.15 samples into the filter with random gaps and output
// stalls, predicts every filtered sample from a local delay line and the
// package coefficient ROM, and compares each result in order.
// ----------------------------------------------------------------------------
module fir_lowpass_104_tap_test;

  localparam int TAPS    = flp104_pkg::TAP_COUNT;
  localparam int SAMP_W  = flp104_pkg::SAMPLE_WIDTH;
  localparam int COEF_W  = flp104_pkg::COEF_WIDTH;
  localparam int DATA_W  = ((SAMP_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 600;

  // Stimulus segment shapes for the random part
  typedef enum int {
    SEG_NOISE,
    SEG_QUIET,
    SEG_RAIL,
    SEG_DC,
    SEG_TONE,
    SEG_CLIP
  } seg_kind_e;

  // Golden filter model and queue of filtered samples still owed by the block
  class fir_scoreboard;
    logic signed [SAMP_W-1:0] history [TAPS];
    int unsigned              head_slot;
    logic signed [SAMP_W-1:0] pending_out_q [$];
    int                       errors;
    int                       n_checked;

    function new();
      foreach (history[i]) history[i] = '0;
      head_slot = TAPS - 1;
      errors    = 0;
      n_checked = 0;
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    // Store the accepted sample and compute the output it produces
    function void note_sample(input logic signed [SAMP_W-1:0] smp);
      longint                   acc;
      longint                   rounded;
      int unsigned              slot;
      logic signed [SAMP_W-1:0] y;
      history[head_slot] = smp;
      acc = 0;
      for (int k = 0; k < TAPS; k++) begin
        slot = (head_slot + k) % TAPS;
        acc += longint'(history[slot]) * longint'(flp104_pkg::COEF_ROM[k]);
      end
      // round half up, then clamp to the sample range
      rounded = (acc + (64'sd1 <<< (COEF_W - 2))) >>> (COEF_W - 1);
      if (rounded > longint'((1 << (SAMP_W - 1)) - 1)) begin
        y = {1'b0, {(SAMP_W - 1){1'b1}}};
      end else if (rounded < -longint'(1 << (SAMP_W - 1))) begin
        y = {1'b1, {(SAMP_W - 1){1'b0}}};
      end else begin
        y = rounded[SAMP_W-1:0];
      end
      pending_out_q.push_back(y);
      head_slot = (head_slot == 0) ? TAPS - 1 : head_slot - 1;
    endfunction

    task check_output(input logic [DATA_W-1:0] got);
      logic signed [SAMP_W-1:0] want;
      n_checked++;
      if (pending_out_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d: sample_out %0d",
                                  n_checked, $signed(got[SAMP_W-1:0])));
      end else begin
        want = pending_out_q.pop_front();
        if (got[SAMP_W-1:0] !== want) begin
          report_mismatch($sformatf("result %0d sample_out: got %0d, want %0d",
                                    n_checked, $signed(got[SAMP_W-1:0]), want));
        end
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [DATA_W-1:0] s_axis_tdata_i;   // sample_in
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [DATA_W-1:0] m_axis_tdata_o;   // sample_out

  fir_scoreboard filter_sb = new();
  bit            steady;
  int            n_sent;
  int            rx_hold;

  fir_lowpass_104_tap u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Output side: random stalls, now and then a long one, none while steady
  always @(negedge clk_i) begin
    if (steady) begin
      m_axis_tready_i <= 1'b1;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(99) == 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold <= $urandom_range(150, 10);
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= 28);
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      filter_sb.check_output(m_axis_tdata_o);
    end
  end

  // Drive one sample; called at a falling edge, returns at a falling edge
  task send_sample(input logic signed [SAMP_W-1:0] smp);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 28) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(130, 4) : $urandom_range(3, 1);
    end
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= DATA_W'(smp);
    do @(posedge clk_i); while (!s_axis_tready_o);
    filter_sb.note_sample(smp);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input until every owed result has come back
  task drain_outputs();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (filter_sb.pending_out_q.size() != 0);
  endtask

  // Stimulus
  initial begin
    logic signed [SAMP_W-1:0] directed_q [$];
    logic signed [SAMP_W-1:0] smp;
    logic signed [SAMP_W-1:0] level;
    seg_kind_e                kind;
    int                       seg;
    int                       seg_len;
    int                       sent_random;
    int                       steady_from;
    int                       steady_len;
    bit                       neg_clip;
    bit                       coef_pos;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    steady          = 1'b0;
    rx_hold         = 0;
    n_sent          = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: impulses into an empty line, rails, bit patterns, steps
    directed_q = '{16'sh7fff, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000,
                   16'sh0001, 16'shffff, 16'sh5555, 16'shaaaa, 16'sh4000,
                   16'shc000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                   16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000,
                   16'sh3039, 16'shcfc7, 16'sh00ff, 16'shff00};
    foreach (directed_q[i]) send_sample(directed_q[i]);
    drain_outputs();

    // Random: shaped segments, with a stretch free of idling
    steady_from = n_sent + $urandom_range(300, 150);
    steady_len  = $urandom_range(160, 100);
    sent_random = 0;
    seg         = 0;
    while (sent_random < RANDOM_ITEMS) begin
      neg_clip = (seg == 4);
      if (seg == 1 || seg == 4) begin
        kind    = SEG_CLIP;
        seg_len = TAPS + $urandom_range(6);
      end else begin
        kind    = seg_kind_e'($urandom_range(SEG_TONE));
        seg_len = $urandom_range(60, 8);
      end
      level = SAMP_W'($urandom_range(65535));
      for (int i = 0; i < seg_len; i++) begin
        case (kind)
          SEG_NOISE: smp = SAMP_W'($urandom_range(65535));
          SEG_QUIET: smp = SAMP_W'(int'($urandom_range(510)) - 255);
          SEG_RAIL:  smp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          SEG_DC:    smp = level;
          SEG_TONE:  smp = (i % 2) ? -level : level;
          default: begin
            // line up each sample with the sign of the tap that will see it
            coef_pos = (flp104_pkg::COEF_ROM[TAPS - 1 - (i % TAPS)] >= 0);
            smp = (coef_pos ^ neg_clip) ? 16'sh7fff : 16'sh8000;
          end
        endcase
        if (n_sent == steady_from) steady <= 1'b1;
        if (n_sent == steady_from + steady_len) steady <= 1'b0;
        send_sample(smp);
        sent_random++;
      end
      if (seg == 6) drain_outputs();
      seg++;
    end

    // Wind down: wait for the last results, then watch for strays
    s_axis_tvalid_i <= 1'b0;
    while (filter_sb.pending_out_q.size() != 0) @(negedge clk_i);
    repeat (TAPS + 20) @(negedge clk_i);
    if (filter_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2500000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
